@@ src/kwsm_pkg.sv @@
package kwsm_pkg;

   // fixed field widths
   localparam int SRC_W = 4;
   localparam int CFG_W = 5;

   // defaults for the top level parameters
   localparam int DEF_MAX_SOURCES = 16;
   localparam int DEF_VALUE_WIDTH = 32;

   // source_count after reset
   localparam logic [CFG_W-1:0] RESET_SOURCE_COUNT = CFG_W'(2);

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EMIT
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic wr_head;
      logic clr_best;
      logic load_out;
      logic out_empty;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic             root_valid;
      logic [SRC_W-1:0] root_source;
      logic             out_free;
   } dp_status_type;

endpackage

@@ src/kwsm_datapath.sv @@
module kwsm_datapath import kwsm_pkg::*; #(
   parameter int MAX_SOURCES = DEF_MAX_SOURCES,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SRC_W-1:0]       req_source,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   req_exhausted,
   input  dp_cmd_type             dp_cmd,
   output dp_status_type          dp_status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_WIDTH-1:0] rsp_merged_value,
   output logic [SRC_W-1:0]       rsp_from_source,
   output logic                   rsp_has_value,
   output logic                   rsp_last
);

   localparam int LEVELS = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int LEAVES = 1 << LEVELS;
   localparam int IDX_W  = LEVELS;

   typedef struct packed {
      logic                   valid;
      logic                   multi;
      logic [IDX_W-1:0]       idx;
      logic [VALUE_WIDTH-1:0] value;
   } node_type;

   // smaller head wins, left side (lower index) on ties
   function automatic node_type pick_node(input node_type lo, input node_type hi);
      node_type res;
      logic     take_lo;
      take_lo = lo.valid && (!hi.valid || ($signed(lo.value) <= $signed(hi.value)));
      res = take_lo ? lo : hi;
      res.valid = lo.valid | hi.valid;
      res.multi = lo.multi | hi.multi | (lo.valid & hi.valid);
      return res;
   endfunction

   logic [VALUE_WIDTH-1:0] head_value_ff [MAX_SOURCES];
   logic [MAX_SOURCES-1:0] head_valid_ff;
   node_type               tree_ff  [1:LEAVES-1];
   node_type               node_all [1:2*LEAVES-1];
   node_type               root;
   logic [IDX_W-1:0]       wr_idx;

   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] merged_value_ff;
   logic [SRC_W-1:0]       from_source_ff;
   logic                   has_value_ff;
   logic                   last_ff;

   assign wr_idx = IDX_W'(req_source);
   assign root   = tree_ff[1];

   // head values, written at the refilled source
   always_ff @(posedge clock) begin
      if (dp_cmd.wr_head && !req_exhausted) begin
         head_value_ff[wr_idx] <= req_value;
      end
   end

   // head valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
      end else if (dp_cmd.wr_head) begin
         head_valid_ff[wr_idx] <= !req_exhausted;
      end else if (dp_cmd.clr_best) begin
         head_valid_ff[root.idx] <= 1'b0;
      end
   end

   // registered min tree, one level per cycle, root at node 1
   genvar g;
   generate
      for (g = 1; g < LEAVES; g++) begin : g_inner
         assign node_all[g] = tree_ff[g];
         always_ff @(posedge clock) begin
            tree_ff[g] <= pick_node(node_all[2*g], node_all[2*g+1]);
         end
      end
      for (g = 0; g < LEAVES; g++) begin : g_leaf
         if (g < MAX_SOURCES) begin : g_used
            assign node_all[LEAVES+g] = '{valid: head_valid_ff[g], multi: 1'b0,
                                          idx: IDX_W'(g), value: head_value_ff[g]};
         end else begin : g_pad
            assign node_all[LEAVES+g] = '0;
         end
      end
   endgenerate

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_out) begin
         if (dp_cmd.out_empty) begin
            merged_value_ff <= '0;
            from_source_ff  <= '0;
            has_value_ff    <= 1'b0;
            last_ff         <= 1'b1;
         end else begin
            merged_value_ff <= root.value;
            from_source_ff  <= SRC_W'(root.idx);
            has_value_ff    <= 1'b1;
            last_ff         <= !root.multi;
         end
      end
   end

   // status
   assign dp_status.root_valid  = root.valid;
   assign dp_status.root_source = SRC_W'(root.idx);
   assign dp_status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = merged_value_ff;
   assign rsp_from_source  = from_source_ff;
   assign rsp_has_value    = has_value_ff;
   assign rsp_last         = last_ff;

endmodule

@@ src/kwsm_ctrl.sv @@
module kwsm_ctrl import kwsm_pkg::*; #(
   parameter int MAX_SOURCES = DEF_MAX_SOURCES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [SRC_W-1:0] req_source,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_source_count,
   output dp_cmd_type       dp_cmd,
   input  dp_status_type    dp_status
);

   localparam int LEVELS = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int CNT_W  = $clog2(MAX_SOURCES + 1);
   localparam int SCW    = $clog2(LEVELS + 1);

   ctl_state_type    state_ff, state_in;
   logic [CFG_W-1:0] source_count_ff;
   logic             loading_ff, loading_in;
   logic [CNT_W-1:0] loaded_cnt_ff, loaded_cnt_in;
   logic [SRC_W-1:0] awaited_ff, awaited_in;
   logic [SCW-1:0]   search_cnt_ff, search_cnt_in;
   logic [CNT_W-1:0] eff_count;
   logic [CNT_W-1:0] next_count;
   logic             src_match;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         source_count_ff <= RESET_SOURCE_COUNT;
      end else if (csr_valid) begin
         source_count_ff <= csr_source_count;
      end
   end

   // effective source count, clamped to 1..MAX_SOURCES
   always_comb begin
      if (source_count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (32'(source_count_ff) > MAX_SOURCES) begin
         eff_count = CNT_W'(MAX_SOURCES);
      end else begin
         eff_count = CNT_W'(source_count_ff);
      end
   end

   assign next_count = loaded_cnt_ff + 1'b1;
   assign src_match  = (req_source == awaited_ff) && (32'(req_source) < MAX_SOURCES);
   assign req_ready  = (state_ff == ST_IDLE);

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         loading_ff    <= 1'b1;
         loaded_cnt_ff <= '0;
         awaited_ff    <= '0;
         search_cnt_ff <= '0;
      end else begin
         state_ff      <= state_in;
         loading_ff    <= loading_in;
         loaded_cnt_ff <= loaded_cnt_in;
         awaited_ff    <= awaited_in;
         search_cnt_ff <= search_cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      loading_in    = loading_ff;
      loaded_cnt_in = loaded_cnt_ff;
      awaited_in    = awaited_ff;
      search_cnt_in = search_cnt_ff;
      dp_cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            search_cnt_in = '0;
            if (req_valid && src_match) begin
               dp_cmd.wr_head = 1'b1;
               if (loading_ff) begin
                  loaded_cnt_in = next_count;
                  if (next_count < eff_count) begin
                     awaited_in = SRC_W'(next_count);
                  end else begin
                     state_in = ST_SEARCH;
                  end
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         // wait for the new head to reach the tree root
         ST_SEARCH: begin
            search_cnt_in = search_cnt_ff + 1'b1;
            if (search_cnt_ff == SCW'(LEVELS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (dp_status.root_valid) begin
               if (dp_status.out_free) begin
                  dp_cmd.load_out = 1'b1;
                  dp_cmd.clr_best = 1'b1;
                  loading_in      = 1'b0;
                  awaited_in      = dp_status.root_source;
                  state_in        = ST_IDLE;
               end
            end else if (loading_ff) begin
               // every source empty from the start
               if (dp_status.out_free) begin
                  dp_cmd.load_out  = 1'b1;
                  dp_cmd.out_empty = 1'b1;
                  loading_in       = 1'b1;
                  loaded_cnt_in    = '0;
                  awaited_in       = '0;
                  state_in         = ST_IDLE;
               end
            end else begin
               // merge done, back to loading without a result
               loading_in    = 1'b1;
               loaded_cnt_in = '0;
               awaited_in    = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/k_way_sorted_merge.sv @@
// k-way merge of ascending streams into one ascending stream.
// req channel: one item per source (req_source, req_value, req_exhausted).
//   Load phase: heads come from source 0, 1, ... up to the configured count.
//   Then each item must come from the source named by the last rsp_from_source;
//   items from any other source are taken and dropped.
// rsp channel: smallest held head, its source, has_value and last.
//   If all sources are empty from the start, one item with has_value 0, last 1.
//   After a last result, an exhausted refill ends the merge with no result and
//   the block returns to the load phase.
// csr channel: writes source_count (0 acts as 1, above MAX_SOURCES clamps).
// Flow: a load item that causes no result leaves the block ready for the next
//   item. Any other item is followed by a search, while the new head rises
//   through the registered min tree over the heads, one level per cycle, and
//   an emit that loads the result if there is one; no new item is taken before.
// A held result does not block the next item; a new result waits in the
//   controller until the output register is taken.
// Reset: source_count 2, all heads empty, load phase awaiting source 0.
module k_way_sorted_merge import kwsm_pkg::*; #(
   parameter int MAX_SOURCES = DEF_MAX_SOURCES,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SRC_W-1:0]       req_source,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   req_exhausted,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_WIDTH-1:0] rsp_merged_value,
   output logic [SRC_W-1:0]       rsp_from_source,
   output logic                   rsp_has_value,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CFG_W-1:0]       csr_source_count
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // controller
   kwsm_ctrl #(
      .MAX_SOURCES (MAX_SOURCES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_source       (req_source),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_source_count (csr_source_count),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status)
   );

   // heads, min tree and output register
   kwsm_datapath #(
      .MAX_SOURCES (MAX_SOURCES),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_source       (req_source),
      .req_value        (req_value),
      .req_exhausted    (req_exhausted),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_merged_value (rsp_merged_value),
      .rsp_from_source  (rsp_from_source),
      .rsp_has_value    (rsp_has_value),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_out |-> dp_status.out_free)
      else $error("result loaded while output register busy");

   // a valued result comes only from a valid tree root
   a_root_valid: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.load_out && !dp_cmd.out_empty) |-> dp_status.root_valid)
      else $error("result loaded from empty tree");

   // head write and best clear never collide
   a_wr_clr: assert property (@(posedge clock) disable iff (reset)
      !(dp_cmd.wr_head && dp_cmd.clr_best))
      else $error("head write and clear in same cycle");

   // after a result is loaded the block is ready for the refill
   a_ready_after: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.load_out |=> req_ready)
      else $error("not ready after result");
`endif

endmodule
